### rtl/mbos_pkg.sv
// Shared types, constants and control structs for the mark bitmap object scanner.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mbos_pkg;

  // Fixed port widths
  localparam int MAP_WORD_W  = 64;
  localparam int OFFSET_W    = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Default structural parameters
  localparam int SLOTS_PER_BIT_DEF = 2;
  localparam int WORD_BITS_DEF     = 64;
  localparam int OFFSET_BITS_DEF   = 32;

  typedef logic [MAP_WORD_W-1:0]  map_word_t;
  typedef logic [OFFSET_W-1:0]    offset_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // Register indexes
  localparam cfg_index_t REG_CHUNK_BASE = CFG_INDEX_W'(0);
  localparam cfg_index_t REG_CHUNK_TOP  = CFG_INDEX_W'(1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_DIV_A,
    ST_DIV_B,
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load_a;
    logic div_step;
    logic load_b;
    logic div_finish;
    logic take_word;
    logic scan;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic div_zero;
    logic finished;
    logic word_any;
    logic word_stop;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/mbos_if.sv
// Channel interfaces: bitmap word input and object result output.
// Depends on mbos_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface mbos_in_if import mbos_pkg::*; ();
  logic      valid;
  logic      ready;
  map_word_t map_word;

  modport source (output valid, output map_word, input ready);
  modport sink   (input valid, input map_word, output ready);
endinterface

interface mbos_out_if import mbos_pkg::*; ();
  logic    valid;
  logic    ready;
  offset_t object_offset;
  logic    object_found;
  logic    word_done;
  logic    range_done;

  modport source (output valid, output object_offset, output object_found,
                  output word_done, output range_done, input ready);
  modport sink   (input valid, input object_offset, input object_found,
                  input word_done, input range_done, output ready);
endinterface

`default_nettype wire

### rtl/mbos_dp.sv
// Datapath: config registers, reciprocal-multiply restart split, set-bit scanner,
// pending result and output register. Driven by mbos_ctrl; uses mbos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbos_dp import mbos_pkg::*; #(
  parameter int SLOTS_PER_BIT = SLOTS_PER_BIT_DEF,
  parameter int WORD_BITS     = WORD_BITS_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  input  logic         cfg_we,
  input  cfg_index_t   cfg_index,
  input  cfg_data_t    cfg_data,
  input  map_word_t    map_word,
  input  logic         obj_ready,
  output logic         obj_valid,
  output offset_t      object_offset,
  output logic         object_found,
  output logic         word_done,
  output logic         range_done
);

  localparam int OB = OFFSET_BITS;
  localparam int WB = WORD_BITS;
  localparam int HB = $clog2(WB);
  localparam int DA = SLOTS_PER_BIT * WORD_BITS;   // slots covered by one word
  localparam int LD = $clog2(DA);

  // base / DA as (base * M1) >> S1, exact for every OB-bit base
  localparam int          S1 = OB + LD;
  localparam int          MW = S1 + 1;
  localparam logic [63:0] M1 = ((64'd1 << S1) + 64'(DA) - 64'd1) / 64'(DA);

  // product built 16 base bits per cycle, high chunk first
  localparam int CH  = 16;
  localparam int NCH = (OB + CH - 1) / CH;
  localparam int PW  = NCH * CH;
  localparam int AW  = PW + MW;
  localparam int CW  = $clog2(NCH + 1);

  // bit index in the word: slot remainder / SLOTS_PER_BIT, same scheme
  localparam int          S2  = LD + $clog2(SLOTS_PER_BIT);
  localparam int          M2W = S2 + 1;
  localparam logic [63:0] M2  = ((64'd1 << S2) + 64'(SLOTS_PER_BIT) - 64'd1) /
                                64'(SLOTS_PER_BIT);

  logic [OB-1:0] chunk_base;
  logic [OB-1:0] chunk_top;

  // restart split
  logic [PW-1:0]      mul_sh;      // base bits not yet multiplied
  logic [AW-1:0]      mul_acc;
  logic [CW-1:0]      div_cnt;
  logic [CH+MW-1:0]   mul_part;
  logic [AW-1:0]      acc_next;
  logic [OB-1:0]      word_quo;
  logic [OB-1:0]      wbase_split;
  logic [LD-1:0]      slot_rem;
  logic [LD+M2W-1:0]  rem_prod;
  logic [HB-1:0]      head_split;

  // scan state
  logic [OB-1:0] wbase;      // slot offset of bit 0 of the current word
  logic [HB-1:0] head;
  logic          finished;
  logic [WB-1:0] mask;
  logic          pend_valid;
  offset_t       pend_ofs;

  logic          out_valid;
  offset_t       out_ofs;
  logic          out_found;
  logic          out_wdone;
  logic          out_rdone;

  logic [HB-1:0] idx;
  logic          any;
  logic [OB:0]   ofs;
  logic          stop;
  logic [OB:0]   next_sum;
  logic [OB-1:0] next_sat;
  logic          next_fin;
  logic          out_free;
  logic          out_write;
  logic          cfg_hit;
  logic          scan_live;

  always_comb begin
    mul_part    = (CH+MW)'(mul_sh[PW-1 -: CH]) * (CH+MW)'(M1[MW-1:0]);
    acc_next    = (mul_acc << CH) + AW'(mul_part);
    word_quo    = mul_acc[S1 +: OB];
    wbase_split = word_quo * OB'(DA);
    slot_rem    = LD'(chunk_base - wbase);
    rem_prod    = (LD+M2W)'(slot_rem) * (LD+M2W)'(M2[M2W-1:0]);
    head_split  = rem_prod[S2 +: HB];
  end

  // lowest set bit of the remaining word
  always_comb begin
    idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = HB'(i);
      end
    end
  end

  always_comb begin
    any       = |mask;
    ofs       = {1'b0, wbase} + ((OB+1)'(idx) * (OB+1)'(SLOTS_PER_BIT));
    stop      = any && (ofs >= {1'b0, chunk_top});
    next_sum  = {1'b0, wbase} + (OB+1)'(DA);
    next_sat  = next_sum[OB] ? {OB{1'b1}} : next_sum[OB-1:0];
    next_fin  = (next_sat >= chunk_top);
    out_free  = !out_valid || obj_ready;
    scan_live = cmd.scan && !finished;
    out_write = cmd.scan && (finished || !any || stop || pend_valid);
    cfg_hit   = cfg_we && ((cfg_index == REG_CHUNK_BASE) || (cfg_index == REG_CHUNK_TOP));
  end

  always_comb begin
    status.cfg_hit   = cfg_hit;
    status.div_zero  = (div_cnt == '0);
    status.finished  = finished;
    status.word_any  = any;
    status.word_stop = stop;
    status.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_base <= '0;
      chunk_top  <= '0;
      div_cnt    <= '0;
      finished   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHUNK_BASE: chunk_base <= OB'(cfg_data);
          REG_CHUNK_TOP:  chunk_top  <= OB'(cfg_data);
          default: ;
        endcase
      end

      if (cmd.load_a) begin
        div_cnt <= CW'(NCH);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - CW'(1);
      end

      if (cmd.div_finish) begin
        finished <= (chunk_base >= chunk_top);
      end else if (scan_live) begin
        if (stop) begin
          finished <= 1'b1;
        end else if (!any) begin
          finished <= next_fin;
        end
      end

      if (scan_live) begin
        pend_valid <= any && !stop;
      end else if (cmd.scan) begin
        pend_valid <= 1'b0;
      end

      if (out_write) begin
        out_valid <= 1'b1;
      end else if (obj_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      mul_sh  <= PW'(chunk_base);
      mul_acc <= '0;
    end else if (cmd.div_step) begin
      mul_sh  <= mul_sh << CH;
      mul_acc <= acc_next;
    end

    if (cmd.load_b) begin
      wbase <= wbase_split;
    end

    if (cmd.div_finish) begin
      head <= head_split;
    end

    if (cmd.take_word) begin
      mask <= map_word[WB-1:0] & ({WB{1'b1}} << head);
    end else if (scan_live) begin
      if (any && !stop) begin
        mask     <= mask & (mask - WB'(1));
        pend_ofs <= offset_t'(ofs[OB-1:0]);
      end else begin
        head <= '0;
        if (!any) begin
          wbase <= next_sat;
        end
      end
    end

    if (out_write) begin
      priority if (finished) begin
        out_ofs   <= '0;
        out_found <= 1'b0;
        out_wdone <= 1'b1;
        out_rdone <= 1'b1;
      end else if (any && !stop) begin
        out_ofs   <= pend_ofs;
        out_found <= 1'b1;
        out_wdone <= 1'b0;
        out_rdone <= 1'b0;
      end else begin
        out_ofs   <= pend_valid ? pend_ofs : '0;
        out_found <= pend_valid;
        out_wdone <= 1'b1;
        out_rdone <= stop ? 1'b1 : next_fin;
      end
    end
  end

  assign obj_valid     = out_valid;
  assign object_offset = out_ofs;
  assign object_found  = out_found;
  assign word_done     = out_wdone;
  assign range_done    = out_rdone;

endmodule

`default_nettype wire

### rtl/mbos_ctrl.sv
// Controller FSM: restart division sequence, word accept and scan stepping.
// Talks to mbos_dp through ctrl_cmd_t / ctrl_status_t from mbos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbos_ctrl import mbos_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   word_end;

  assign word_end = status.out_free &&
                    (status.finished || !status.word_any || status.word_stop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (status.cfg_hit) begin
      state_next = ST_INIT;
    end else begin
      unique case (state)
        ST_INIT:  state_next = ST_DIV_A;
        ST_DIV_A: if (status.div_zero) state_next = ST_DIV_B;
        ST_DIV_B: if (status.div_zero) state_next = ST_IDLE;
        ST_IDLE:  if (in_valid) state_next = ST_SCAN;
        ST_SCAN:  if (word_end) state_next = ST_IDLE;
        default:  state_next = ST_INIT;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_INIT: begin
        cmd.load_a = 1'b1;
      end
      ST_DIV_A: begin
        cmd.div_step = !status.div_zero;
        cmd.load_b   = status.div_zero;
      end
      ST_DIV_B: begin
        cmd.div_step   = !status.div_zero;
        cmd.div_finish = status.div_zero;
      end
      ST_IDLE: begin
        cmd.take_word = !status.cfg_hit;
      end
      ST_SCAN: begin
        cmd.scan = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/mark_bitmap_object_scanner_top.sv
// Mark bitmap object scanner: reports the slot offset of every marked object
// in a heap chunk, one result per object. Uses mbos_pkg, mbos_if, mbos_ctrl
// and mbos_dp.
//
// Channels: map_in takes one bitmap word per handshake, starting with the word
// that covers chunk_base; obj_out gives one word per object found (or one
// empty result per bitmap word), word_done on the last of each bitmap word.
// Config: cfg_we/cfg_index/cfg_data write chunk_base (0) or chunk_top (1);
// any such write restarts the scan at chunk_base.
// Restart: after reset or a config write the base is split into word base and
// bit position by reciprocal multiplication, 16 base bits per cycle, and
// map_in.ready stays low meanwhile.
// Per word: the word is accepted, then the find-first-set scanner takes one
// step per reported object and one for the end of the word, stepping only
// while the output register is free. Results are held back one step so
// word_done can be set.
// Stall: results sit in an output register; the scan stops while it is full
// and not taken, and no new word is taken until the current word completes.
`timescale 1ns / 1ps
`default_nettype none

module mark_bitmap_object_scanner_top import mbos_pkg::*; #(
  parameter int SLOTS_PER_BIT = SLOTS_PER_BIT_DEF,
  parameter int WORD_BITS     = WORD_BITS_DEF,
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data,
  mbos_in_if.sink    map_in,
  mbos_out_if.source obj_out
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  mbos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (map_in.valid),
    .status   (status),
    .cmd      (cmd)
  );

  mbos_dp #(
    .SLOTS_PER_BIT (SLOTS_PER_BIT),
    .WORD_BITS     (WORD_BITS),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .map_word      (map_in.map_word),
    .obj_ready     (obj_out.ready),
    .obj_valid     (obj_out.valid),
    .object_offset (obj_out.object_offset),
    .object_found  (obj_out.object_found),
    .word_done     (obj_out.word_done),
    .range_done    (obj_out.range_done)
  );

  assign map_in.ready = cmd.take_word;

endmodule

`default_nettype wire

### rtl/mbos_checker.sv
// Port-level checks on the scanner's result channel, bound to the top level.
// Uses mbos_pkg for the offset type.
`timescale 1ns / 1ps
`default_nettype none

module mbos_checker import mbos_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input offset_t object_offset,
  input logic    object_found,
  input logic    word_done,
  input logic    range_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !object_found |-> word_done)
    else $error("empty result not marked as end of word");

  a_range_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_done |-> !range_done)
    else $error("range_done before end of word");

  a_empty_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !object_found |-> object_offset == '0)
    else $error("empty result carries an offset");

endmodule

bind mark_bitmap_object_scanner_top mbos_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (obj_out.valid),
  .out_ready     (obj_out.ready),
  .object_offset (obj_out.object_offset),
  .object_found  (obj_out.object_found),
  .word_done     (obj_out.word_done),
  .range_done    (obj_out.range_done)
);

`default_nettype wire
